// ===== hw/rtl/wir_pkg.sv =====
// ----------------------------------------------------------------------------
// wir_pkg
// Shared types and constants for the weighted isotonic regression block.
// ----------------------------------------------------------------------------
`default_nettype none
package wir_pkg;
  localparam int MAX_ITEMS_DEF = 64;
  localparam int VAL_W = 32;
  localparam int WGT_W = 16;
  localparam int SUM_W = 22;
  localparam int PROD_W = 54;
  localparam int NUM_W = 55;

  // register byte addresses
  localparam logic [1:0] ADDR_DECREASING_MODE = 2'd0;

  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
    logic [WGT_W-1:0]        sample_weight;
    logic                    is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] fitted_value;
    logic                    end_of_run;
    logic                    overflowed;
  } out_item_t;
endpackage
`default_nettype wire

// ===== hw/rtl/weighted_isotonic_regression.sv =====
// ----------------------------------------------------------------------------
// weighted_isotonic_regression
// Weighted pool-adjacent-violators fit with APB mode register.
// ----------------------------------------------------------------------------
// Items are taken one at a time when start is high and busy is low. An item
// pushed on an empty stack, or dropped when full, needs only its accept step;
// otherwise it is accepted, then the block below it is read and compared, and
// each merge it triggers runs read, compare, multiply, the 55-step bit-serial
// divider and write back, skipping the divider when both blocks weigh zero.
// After the last item each stored position is emitted on out_valid, one every
// cycle within a block, with a memory read state ahead of each block. Results
// cannot be stalled by the receiver.
`default_nettype none
module weighted_isotonic_regression
  import wir_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
)(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item,
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic [1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  logic decr_r;

  // mode register
  assign pready = 1'b1;
  assign prdata = {31'd0, decr_r};
  always_ff @(posedge clk) begin
    if (!rst_n) decr_r <= 1'b0;
    else if (psel && penable && pwrite && paddr == ADDR_DECREASING_MODE) decr_r <= pwdata[0];
  end

  wir_core #(.MAX_ITEMS(MAX_ITEMS)) u_core (
    .clk(clk), .rst_n(rst_n), .decr(decr_r), .start(start), .in_item(in_item),
    .busy(busy), .out_valid(out_valid), .out_item(out_item)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/wir_div.sv =====
// ----------------------------------------------------------------------------
// wir_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
module wir_div
  import wir_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [NUM_W-1:0]  num,
  input  wire logic [SUM_W-1:0]         den,
  output logic                          done,
  output logic signed [VAL_W-1:0]       quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  mag_r;
  logic [SUM_W:0]    rem_r;
  logic [SUM_W-1:0]  den_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [SUM_W+1:0]  trial;
  logic [SUM_W+1:0]  shifted;
  logic [NUM_W-1:0]  qneg;

  // shift in next numerator bit and try subtract
  assign shifted = {rem_r, mag_r[NUM_W-1]};
  assign trial   = shifted - {2'b00, den_r};
  assign qneg    = -mag_r;
  assign quo     = neg_r ? qneg[VAL_W-1:0] : mag_r[VAL_W-1:0];
  assign done    = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        neg_r  <= num[NUM_W-1];
        mag_r  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        if (!trial[SUM_W+1]) begin
          rem_r <= trial[SUM_W:0];
          mag_r <= {mag_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[SUM_W:0];
          mag_r <= {mag_r[NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/wir_core.sv =====
// ----------------------------------------------------------------------------
// wir_core
// Block stack in synchronous memory, merge sequencer and emission sweep.
// ----------------------------------------------------------------------------
`default_nettype none
module wir_core
  import wir_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
)(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       decr,
  input  wire logic       start,
  input  wire in_item_t   in_item,
  output logic            busy,
  output logic            out_valid,
  output out_item_t       out_item
);
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD    = 8'b0000_0010,
    S_CHK   = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_WB    = 8'b0010_0000,
    S_ERD   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] mean;
    logic [SUM_W-1:0]        wgt;
    logic [CNT_W-1:0]        bend;
  } ent_t;

  // block memory, one entry per block
  ent_t mem [MAX_ITEMS];
  ent_t rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] wa;
  ent_t             wd;

  state_t st_r;
  logic [CNT_W-1:0] top_r, cnt_r, pos_r;
  logic [IDX_W-1:0] k_r;
  logic ovf_r, last_r;
  ent_t up_r, lo_r;
  logic signed [PROD_W-1:0] p1_r, p2_r;
  logic [SUM_W-1:0] wsum_r;
  logic signed [VAL_W-1:0] avg;
  logic signed [VAL_W:0]   msum;
  logic div_start, div_done;
  logic signed [VAL_W-1:0] quo;
  logic viol;
  logic acc, store;
  logic out_valid_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[rd_addr];
  end

  wir_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(NUM_W'(p1_r) + NUM_W'(p2_r)), .den(wsum_r),
    .done(div_done), .quo(quo)
  );

  assign busy  = (st_r != S_IDLE);
  assign acc   = start && !busy;
  assign store = (cnt_r < CNT_W'(MAX_ITEMS)) && (top_r < CNT_W'(MAX_ITEMS));
  assign viol  = decr ? (rd_q.mean < up_r.mean) : (rd_q.mean > up_r.mean);
  assign msum  = {lo_r.mean[VAL_W-1], lo_r.mean} + {up_r.mean[VAL_W-1], up_r.mean};
  assign avg   = VAL_W'((msum + {{VAL_W{1'b0}}, msum[VAL_W]}) >>> 1);
  assign div_start = (st_r == S_MUL) && (wsum_r != '0);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // memory port control
  always_comb begin
    we = 1'b0; wa = up_r.bend[IDX_W-1:0]; wd = up_r;
    rd_addr = k_r;
    if (acc && store) begin
      we = 1'b1; wa = top_r[IDX_W-1:0];
      wd.mean = in_item.sample_value;
      wd.wgt  = SUM_W'(in_item.sample_weight);
      wd.bend = cnt_r + 1'b1;
    end else if (st_r == S_WB) begin
      we = 1'b1; wa = IDX_W'(top_r - 2'd2); wd = up_r;
    end
    if (st_r == S_RD) rd_addr = IDX_W'(top_r - 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; top_r <= '0; cnt_r <= '0; ovf_r <= 1'b0;
      out_valid_r <= 1'b0; last_r <= 1'b0; k_r <= '0; pos_r <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (acc) begin
          last_r <= in_item.is_last;
          if (store) begin
            up_r.mean <= in_item.sample_value;
            up_r.wgt  <= SUM_W'(in_item.sample_weight);
            up_r.bend <= cnt_r + 1'b1;
            cnt_r <= cnt_r + 1'b1;
            top_r <= top_r + 1'b1;
            st_r  <= (top_r != '0) ? S_RD : (in_item.is_last ? S_ERD : S_IDLE);
          end else begin
            ovf_r <= 1'b1;
            st_r  <= in_item.is_last ? S_ERD : S_IDLE;
          end
          k_r <= '0; pos_r <= '0;
        end
        S_RD: st_r <= S_CHK;
        S_CHK: begin
          if (viol) begin
            lo_r <= rd_q;
            p1_r <= PROD_W'($signed({1'b0, rd_q.wgt})) * PROD_W'(rd_q.mean);
            p2_r <= PROD_W'($signed({1'b0, up_r.wgt})) * PROD_W'(up_r.mean);
            wsum_r <= rd_q.wgt + up_r.wgt;
            st_r <= S_MUL;
          end else begin
            st_r <= last_r ? S_ERD : S_IDLE;
          end
        end
        S_MUL: begin
          if (wsum_r == '0) begin
            up_r.mean <= avg; up_r.wgt <= '0; st_r <= S_WB;
          end else st_r <= S_DIV;
        end
        S_DIV: if (div_done) begin
          up_r.mean <= quo; up_r.wgt <= wsum_r; st_r <= S_WB;
        end
        S_WB: begin
          top_r <= top_r - 1'b1;
          st_r  <= (top_r > CNT_W'(2)) ? S_RD : (last_r ? S_ERD : S_IDLE);
        end
        S_ERD: begin
          if (cnt_r == '0) st_r <= S_IDLE;
          else st_r <= S_EMIT;
        end
        S_EMIT: begin
          out_valid_r <= 1'b1;
          out_item_r.fitted_value <= rd_q.mean;
          out_item_r.end_of_run   <= (pos_r + 1'b1 == cnt_r);
          out_item_r.overflowed   <= ovf_r;
          pos_r <= pos_r + 1'b1;
          if (pos_r + 1'b1 == cnt_r) begin
            top_r <= '0; cnt_r <= '0; ovf_r <= 1'b0; st_r <= S_IDLE;
          end else if (pos_r + 1'b1 == rd_q.bend) begin
            k_r <= k_r + 1'b1; st_r <= S_ERD;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/wir_checker.sv =====
// ----------------------------------------------------------------------------
// wir_checker
// Port-level checks for the isotonic regression block.
// ----------------------------------------------------------------------------
`default_nettype none
module wir_checker
  import wir_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire out_item_t out_item
);
  // results only while a run is in flight
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result while idle");
  // end of run closes the run
  a_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.end_of_run |-> !busy) else $error("busy after end");
  // after an accepted item the block is busy or shows no result
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || !out_valid) else $error("accept");
endmodule
bind weighted_isotonic_regression wir_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item));
`default_nettype wire

// ===== dv/tb_weighted_isotonic_regression.sv =====
// ----------------------------------------------------------------------------
// tb_weighted_isotonic_regression
// Drives sequences of weighted samples through the isotonic fit block in both
// fit directions and checks every emitted fitted value against a predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_weighted_isotonic_regression
  import wir_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = MAX_ITEMS_DEF;
  localparam int STALL_LIMIT = 20000;

  // pava predictor and store of expected fits
  class fit_scoreboard;
    bit decreasing;
    longint blk_mean[CAP];
    int unsigned blk_wgt[CAP];
    int unsigned blk_end[CAP];
    int unsigned n_blocks;
    int unsigned n_stored;
    bit dropped;
    out_item_t expected_fits[$];
    int unsigned mismatches;

    function bit out_of_order(longint lo, longint hi);
      return decreasing ? (lo < hi) : (lo > hi);
    endfunction

    // push one sample, pool violators, emit fits on the last one
    function void note_sample(in_item_t it);
      int unsigned a;
      int unsigned wsum;
      int unsigned pos;
      int unsigned first;
      longint num;
      out_item_t fit;
      if (n_stored < CAP && n_blocks < CAP) begin
        blk_mean[n_blocks] = longint'(it.sample_value);
        blk_wgt[n_blocks] = it.sample_weight;
        n_stored++;
        blk_end[n_blocks] = n_stored;
        n_blocks++;
        while (n_blocks >= 2 && out_of_order(blk_mean[n_blocks-2], blk_mean[n_blocks-1])) begin
          a = n_blocks - 2;
          wsum = blk_wgt[a] + blk_wgt[a+1];
          if (wsum == 0) begin
            blk_mean[a] = (blk_mean[a] + blk_mean[a+1]) / 2;
          end else begin
            num = longint'(blk_wgt[a]) * blk_mean[a] + longint'(blk_wgt[a+1]) * blk_mean[a+1];
            blk_mean[a] = num / longint'(wsum);
          end
          blk_wgt[a] = wsum & 32'h3F_FFFF;
          blk_end[a] = blk_end[a+1];
          n_blocks--;
        end
      end else begin
        dropped = 1'b1;
      end
      if (!it.is_last) return;
      first = 0;
      for (int unsigned k = 0; k < n_blocks; k++) begin
        for (pos = first; pos < blk_end[k] && pos < n_stored; pos++) begin
          fit.fitted_value = blk_mean[k][31:0];
          fit.end_of_run = (pos + 1 == n_stored);
          fit.overflowed = dropped;
          expected_fits.push_back(fit);
        end
        first = blk_end[k];
      end
      n_blocks = 0;
      n_stored = 0;
      dropped = 1'b0;
    endfunction

    // compare one emitted fit with the oldest expectation
    function void check_fit(out_item_t got);
      out_item_t exp_fit;
      if (expected_fits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected fit: value %0d end %0b ovf %0b",
                   got.fitted_value, got.end_of_run, got.overflowed);
        return;
      end
      exp_fit = expected_fits.pop_front();
      if (got !== exp_fit) begin
        mismatches++;
        if (mismatches <= 10)
          $display("fit mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                   exp_fit.fitted_value, exp_fit.end_of_run, exp_fit.overflowed,
                   got.fitted_value, got.end_of_run, got.overflowed);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  fit_scoreboard sb = new();
  int unsigned idle_pct;
  int unsigned stall_cycles = 0;
  int unsigned items_sent = 0;

  always #2 clk = ~clk;

  weighted_isotonic_regression u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // result monitor and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_fit(out_item);
      if (out_valid || (start && !busy)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // apb write of the mode register
  task automatic write_mode(bit mode);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_DECREASING_MODE;
    pwdata <= {31'd0, mode};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.decreasing = mode;
  endtask

  // offer one item and hold it until accepted
  task automatic send(logic [31:0] v, logic [15:0] w, bit last);
    int unsigned gap;
    start <= 1'b1;
    in_item <= '{sample_value: v, sample_weight: w, is_last: last};
    do @(posedge clk); while (busy);
    sb.note_sample('{sample_value: v, sample_weight: w, is_last: last});
    items_sent++;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // block idle: all fits in, then allow any trailing work to finish
  task automatic drain();
    start <= 1'b0;
    while (sb.expected_fits.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(2000) - 1000;
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_sequence(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send(rand_value(), rand_weight(), i == len - 1);
  endtask

  task automatic directed_set();
    // single item
    send(32'h7FFF_FFFF, 16'hFFFF, 1'b1);
    // zero weights both sides, extreme values
    send(32'h7FFF_FFFF, 16'd0, 1'b0);
    send(32'h8000_0000, 16'd0, 1'b1);
    // chain of violators with mixed weights and an equal pair
    send(32'h0003_0000, 16'hFFFF, 1'b0);
    send(32'h0003_0000, 16'h1000, 1'b0);
    send(32'h0001_0000, 16'hFFFF, 1'b0);
    send(32'hFFFF_0000, 16'h0001, 1'b0);
    send(32'h0005_0000, 16'h0800, 1'b1);
  endtask

  int unsigned len;

  initial begin
    idle_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part in both fit directions
    directed_set();
    drain();
    write_mode(1'b1);
    directed_set();
    drain();
    // overflow with the last item dropped
    idle_pct = 8;
    random_sequence(CAP + 2);
    drain();

    // random sequences across idle phases and modes
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(ph[0]);
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 56 : 8;
      for (int s = 0; s < 2; s++) begin
        len = $urandom_range(1, 6);
        random_sequence(len);
      end
      // hold off until every fit has come
      drain();
    end
    while (items_sent < 150) begin
      len = $urandom_range(1, 8);
      random_sequence(len);
    end
    start <= 1'b0;
    drain();

    if (sb.mismatches == 0 && sb.expected_fits.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== weighted_isotonic_regression.f =====
hw/rtl/wir_pkg.sv
hw/rtl/wir_div.sv
hw/rtl/wir_core.sv
hw/rtl/weighted_isotonic_regression.sv
hw/rtl/wir_checker.sv
dv/tb_weighted_isotonic_regression.sv
